// ===== hdl/scc_pkg.sv =====
`timescale 1ns / 1ps

package scc_pkg;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICK_RELOAD     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNTDOWN_START = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIX_LIMIT       = 2'd2;

  localparam logic [15:0] TICK_RELOAD_RST     = 16'd1000;
  localparam logic [7:0]  COUNTDOWN_START_RST = 8'd6;
  localparam logic [15:0] FIX_LIMIT_RST       = 16'd65535;

  localparam int MS_PER_SEC = 1000;
  localparam int QUOT_W     = 7;
  localparam int DIV_SHIFT  = 26;
  localparam int PROD_W     = 34;
  localparam logic [16:0] DIV_MULT = 17'd67109;

endpackage

// ===== hdl/start_countdown_controller_top.sv =====
`timescale 1ns / 1ps

// Start-countdown controller.
// Items arrive on the in_ channel: a tick (in_func low) advances the
// countdown timer while counting, and a poll (in_func high) brings the
// button levels and the GPS time. Every item produces exactly one result
// transfer on the out_ channel carrying the mode, event flags and the
// captured start time.
// Configuration registers are written through the cfg_ channel, which is
// always ready; writes are expected only while the block is idle.
// An input transfer passes through an input register, which also holds the
// millisecond quotient from the reciprocal multiplier, then the state update
// and result register. One item is accepted in every cycle while the result
// side keeps taking transfers.
// When the receiver stalls, the result is held and one further item waits
// in the input register; the input channel stalls after that.
// Synchronous reset returns the block to the init mode with no captured
// start and loads the configuration defaults.
module start_countdown_controller_top
  import scc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic                   in_red_button,
  input  logic                   in_green_button,
  input  logic [31:0]            in_gps_seconds,
  input  logic [15:0]            in_gps_millisecond,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_mode,
  output logic                   out_redraw,
  output logic                   out_prompt_event,
  output logic [7:0]             out_prompt_digit,
  output logic                   out_beep_event,
  output logic [31:0]            out_start_seconds,
  output logic [9:0]             out_start_millisecond,
  output logic                   out_start_valid
);

  typedef enum logic [2:0] {
    MODE_INIT  = 3'd0,
    MODE_NOFIX = 3'd1,
    MODE_FIX   = 3'd2,
    MODE_COUNT = 3'd3,
    MODE_HOLD  = 3'd4
  } mode_t;

  logic [15:0] tick_reload_r;
  logic [7:0]  countdown_start_r;
  logic [15:0] fix_limit_r;

  logic              a_valid_r;
  logic              a_func_r;
  logic              a_red_r;
  logic              a_green_r;
  logic [31:0]       a_secs_r;
  logic [15:0]       a_ms_r;
  logic [QUOT_W-1:0] a_quot_r;

  mode_t       mode_r, mode_nxt;
  logic        pending_r, pending_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [31:0] cap_secs_r, cap_secs_nxt;
  logic [9:0]  cap_ms_r, cap_ms_nxt;
  logic        cap_valid_r, cap_valid_nxt;
  logic        red_prev_r, red_prev_nxt;
  logic        green_prev_r, green_prev_nxt;
  logic [31:0] shown_r, shown_nxt;

  logic        redraw_nxt;
  logic        prompt_nxt;
  logic [7:0]  digit_nxt;
  logic        beep_nxt;

  logic [PROD_W-1:0] quot_prod;
  logic [QUOT_W-1:0] quot;
  logic              advance;
  logic              in_accept;
  logic              process;
  logic [15:0]       timer_dec;
  logic [15:0]       ms_rem;
  logic [31:0]       now_secs;
  logic              red_fall;
  logic              green_fall;
  logic              fix;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = a_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign process   = a_valid_r && advance;

  assign quot_prod = PROD_W'(in_gps_millisecond) * PROD_W'(DIV_MULT);
  assign quot      = QUOT_W'(quot_prod >> DIV_SHIFT);

  assign timer_dec  = timer_r - 16'd1;
  assign ms_rem     = a_ms_r - (16'(a_quot_r) * 16'(MS_PER_SEC));
  assign now_secs   = a_secs_r + 32'(a_quot_r);
  assign red_fall   = red_prev_r && !a_red_r;
  assign green_fall = green_prev_r && !a_green_r;
  assign fix        = a_ms_r < fix_limit_r;

  always_comb begin
    mode_nxt       = mode_r;
    pending_nxt    = pending_r;
    count_nxt      = count_r;
    timer_nxt      = timer_r;
    cap_secs_nxt   = cap_secs_r;
    cap_ms_nxt     = cap_ms_r;
    cap_valid_nxt  = cap_valid_r;
    red_prev_nxt   = red_prev_r;
    green_prev_nxt = green_prev_r;
    shown_nxt      = shown_r;
    redraw_nxt     = 1'b0;
    prompt_nxt     = 1'b0;
    digit_nxt      = 8'd0;
    beep_nxt       = 1'b0;

    if (a_func_r == FUNC_TICK) begin
      if (mode_r == MODE_COUNT) begin
        timer_nxt = timer_dec;
        if (timer_dec == 16'd0) begin
          timer_nxt   = tick_reload_r;
          pending_nxt = 1'b1;
          if (count_r != 8'd0) begin
            count_nxt = count_r - 8'd1;
          end
        end
      end
    end else begin
      unique case (mode_r)
        MODE_INIT: begin
          mode_nxt   = MODE_NOFIX;
          redraw_nxt = 1'b1;
        end
        MODE_NOFIX: begin
          if (fix) begin
            mode_nxt   = MODE_FIX;
            redraw_nxt = 1'b1;
          end
        end
        MODE_FIX: begin
          if (!fix) begin
            mode_nxt   = MODE_NOFIX;
            redraw_nxt = 1'b1;
          end else if (green_fall) begin
            mode_nxt   = MODE_COUNT;
            count_nxt  = countdown_start_r;
            timer_nxt  = tick_reload_r;
            redraw_nxt = 1'b1;
          end else if (red_fall && cap_valid_r) begin
            mode_nxt   = MODE_HOLD;
            redraw_nxt = 1'b1;
          end
        end
        default: begin
          if (red_fall) begin
            mode_nxt   = MODE_NOFIX;
            redraw_nxt = 1'b1;
          end
        end
      endcase

      if (pending_r) begin
        if (count_nxt == 8'd0) begin
          cap_secs_nxt  = now_secs;
          cap_ms_nxt    = ms_rem[9:0];
          cap_valid_nxt = 1'b1;
          beep_nxt      = 1'b1;
          mode_nxt      = MODE_HOLD;
          redraw_nxt    = 1'b1;
        end else begin
          prompt_nxt = 1'b1;
          digit_nxt  = count_nxt;
        end
        pending_nxt = 1'b0;
      end

      if (mode_nxt == MODE_FIX) begin
        if (now_secs != shown_r) begin
          redraw_nxt = 1'b1;
        end
        if (redraw_nxt || (now_secs != shown_r)) begin
          shown_nxt = now_secs;
        end
      end

      red_prev_nxt   = a_red_r;
      green_prev_nxt = a_green_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_reload_r     <= TICK_RELOAD_RST;
      countdown_start_r <= COUNTDOWN_START_RST;
      fix_limit_r       <= FIX_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TICK_RELOAD:     tick_reload_r     <= cfg_data;
        CFG_COUNTDOWN_START: countdown_start_r <= cfg_data[7:0];
        CFG_FIX_LIMIT:       fix_limit_r       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance || !a_valid_r) begin
      a_valid_r <= in_accept;
    end
    if (in_accept) begin
      a_func_r  <= in_func;
      a_red_r   <= in_red_button;
      a_green_r <= in_green_button;
      a_secs_r  <= in_gps_seconds;
      a_ms_r    <= in_gps_millisecond;
      a_quot_r  <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_INIT;
      pending_r    <= 1'b0;
      count_r      <= 8'd0;
      timer_r      <= 16'd0;
      cap_secs_r   <= 32'd0;
      cap_ms_r     <= 10'd0;
      cap_valid_r  <= 1'b0;
      red_prev_r   <= 1'b0;
      green_prev_r <= 1'b0;
      shown_r      <= 32'd0;
      out_valid    <= 1'b0;
    end else begin
      if (process) begin
        mode_r       <= mode_nxt;
        pending_r    <= pending_nxt;
        count_r      <= count_nxt;
        timer_r      <= timer_nxt;
        cap_secs_r   <= cap_secs_nxt;
        cap_ms_r     <= cap_ms_nxt;
        cap_valid_r  <= cap_valid_nxt;
        red_prev_r   <= red_prev_nxt;
        green_prev_r <= green_prev_nxt;
        shown_r      <= shown_nxt;
      end
      if (advance) begin
        out_valid <= a_valid_r;
      end
    end
    if (process) begin
      out_mode              <= mode_nxt;
      out_redraw            <= redraw_nxt;
      out_prompt_event      <= prompt_nxt;
      out_prompt_digit      <= digit_nxt;
      out_beep_event        <= beep_nxt;
      out_start_seconds     <= cap_secs_nxt;
      out_start_millisecond <= cap_ms_nxt;
      out_start_valid       <= cap_valid_nxt;
    end
  end

endmodule
